>>> rtl/ppr_pkg.sv
package ppr_pkg;

    localparam logic [1:0] CH_MONO = 2'd1;
    localparam logic [1:0] CH_RESET = CH_MONO;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [1:0] ORDER_NONE   = 2'd0;
    localparam logic [1:0] ORDER_FIRST  = 2'd1;
    localparam logic [1:0] ORDER_SECOND = 2'd2;
    localparam logic [1:0] ORDER_THIRD  = 2'd3;

    localparam int HIST_DEPTH = 6;

    typedef struct packed {
        logic       func;
        logic [1:0] order;
        logic       block_start;
    } ctrl_t;

endpackage

>>> rtl/ppr_history.sv
module ppr_history #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic                   block_start,
    input  logic                   stereo,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] a1,
    output logic [SAMPLE_BITS-1:0] a2,
    output logic [SAMPLE_BITS-1:0] a3
);
    import ppr_pkg::*;

    logic [SAMPLE_BITS-1:0] hist_reg  [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] hist_next [HIST_DEPTH];
    logic [SAMPLE_BITS-1:0] view      [HIST_DEPTH];

    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            view[i] = block_start ? '0 : hist_reg[i];
        end
        hist_next[0] = sample;
        for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_next[i] = view[i-1];
        end
    end

    assign a1 = stereo ? view[1] : view[0];
    assign a2 = stereo ? view[3] : view[1];
    assign a3 = stereo ? view[5] : view[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (shift_en) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

endmodule

>>> rtl/ppr_datapath.sv
module ppr_datapath #(
    parameter int SAMPLE_BITS = 16
) (
    input  ppr_pkg::ctrl_t         ctrl,
    input  logic [SAMPLE_BITS-1:0] value,
    input  logic [SAMPLE_BITS-1:0] a1,
    input  logic [SAMPLE_BITS-1:0] a2,
    input  logic [SAMPLE_BITS-1:0] a3,
    output logic [SAMPLE_BITS-1:0] result,
    output logic [SAMPLE_BITS-1:0] sample
);
    import ppr_pkg::*;

    logic [SAMPLE_BITS-1:0] pred;

    always_comb begin
        unique case (ctrl.order)
            ORDER_FIRST:  pred = a1;
            ORDER_SECOND: pred = (a1 << 1) - a2;
            ORDER_THIRD:  pred = (a1 << 1) + a1 - (a2 << 1) - a2 + a3;
            default:      pred = '0;
        endcase
    end

    always_comb begin
        if (ctrl.func == FUNC_DECODE) begin
            result = value + pred;
            sample = result;
        end else begin
            result = value - pred;
            sample = value;
        end
    end

endmodule

>>> rtl/polynomial_predictor_residual_codec.sv
// Channel  Direction  Handshake          Word
// s_       in         s_valid/s_ready    func, value, order, block_start
// m_       out        m_valid/m_ready    result
// cfg_     in         cfg_we             channels
//
// One word per cycle unless m_ stalls; m_valid rises as the result register loads.
// The word register feeds predictor and history in one pass into the result register.
// aresetn (synchronous) clears history, valid flags and sets channels to mono.
// A stalled m_ side holds the result; one more word waits in the input register.
module polynomial_predictor_residual_codec #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic signed [SAMPLE_BITS-1:0] s_value,
    input  logic [1:0]                    s_order,
    input  logic                          s_block_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_result
);
    import ppr_pkg::*;

    logic [1:0]             channels_reg;
    logic                   in_valid_reg;
    ctrl_t                  in_ctrl_reg;
    logic [SAMPLE_BITS-1:0] in_value_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_result_reg;

    logic                   out_load;
    logic                   in_load;
    logic [SAMPLE_BITS-1:0] a1;
    logic [SAMPLE_BITS-1:0] a2;
    logic [SAMPLE_BITS-1:0] a3;
    logic [SAMPLE_BITS-1:0] result_next;
    logic [SAMPLE_BITS-1:0] sample;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    ppr_history #(.SAMPLE_BITS(SAMPLE_BITS)) u_history (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (out_load),
        .block_start (in_ctrl_reg.block_start),
        .stereo      (channels_reg != CH_MONO),
        .sample      (sample),
        .a1          (a1),
        .a2          (a2),
        .a3          (a3)
    );

    ppr_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
        .ctrl   (in_ctrl_reg),
        .value  (in_value_reg),
        .a1     (a1),
        .a2     (a2),
        .a3     (a3),
        .result (result_next),
        .sample (sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg  <= CH_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                channels_reg <= cfg_wdata;
            end
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_ctrl_reg.func        <= s_func;
            in_ctrl_reg.order       <= s_order;
            in_ctrl_reg.block_start <= s_block_start;
            in_value_reg            <= s_value;
        end
        if (out_load) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

endmodule

>>> rtl/ppr_checker.sv
module ppr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_result
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_valid && s_ready && m_valid && !m_ready) && m_valid && !m_ready
        |-> !s_ready)
        else $error("input accepted past a full pipeline");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!m_valid && !(s_valid && s_ready)) && !m_valid |-> s_ready)
        else $error("empty pipeline refuses a word");

endmodule

bind polynomial_predictor_residual_codec ppr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
